### rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants, register map and the result structure.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// Frame format
	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam int unsigned MIN_TOTAL  = 6;
	localparam int unsigned MAX_FRAME  = 256;

	// Bounds on the length byte, which counts data bytes plus the trailer.
	localparam logic [8:0] LEN_MIN = 9'(MIN_TOTAL - 4);
	localparam logic [8:0] LEN_MAX = 9'(MAX_FRAME - 4);
	localparam logic [7:0] DATA_MAX = 8'(MAX_FRAME - MIN_TOTAL);

	// Configuration register map
	localparam int unsigned PADDR_W = 3;
	localparam logic        REG_REPORT_OPCODE = 1'b0;
	localparam logic [7:0]  REPORT_OPCODE_RST = 8'hBD;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_DATA,
		ST_TRAIL_HI,
		ST_TRAIL_LO
	} sfd_state_t;

	typedef struct packed {
		logic       checksum_ok;
		logic [7:0] frame_opcode;
		logic [7:0] data_length;
		logic [7:0] zone_left;
		logic [7:0] zone_middle;
		logic [7:0] zone_right;
		logic       is_zone_report;
	} sfd_result_t;

endpackage
`default_nettype wire

### rtl/serial_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial frame deframer
// Finds 0x55 0xAA framed packets in a byte stream and checks their checksum.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle. Each byte is captured in
// an input register and handled from there by the hunting and frame
// collection logic; the result of a frame is loaded into the output register
// as its last byte leaves the input register, or later if that byte has to wait
// for the output register to empty. The input stalls only when the last byte
// of a frame is waiting and the previous result has not yet been taken, so a
// stalled output costs no throughput until a second frame ends.
// ----------------------------------------------------------------------------
module serial_frame_deframer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rx_valid,
	output logic                             rx_stall,
	input  wire logic [7:0]                  rx_byte,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic                             checksum_ok,
	output logic      [7:0]                  frame_opcode,
	output logic      [7:0]                  data_length,
	output logic      [7:0]                  zone_left,
	output logic      [7:0]                  zone_middle,
	output logic      [7:0]                  zone_right,
	output logic                             is_zone_report,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import sfd_pkg::*;

	logic [7:0]  report_opcode_val;
	logic        res_free;
	logic        res_load;
	sfd_result_t res_data;
	sfd_result_t res_out;

	sfd_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.report_opcode (report_opcode_val)
	);

	sfd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.report_opcode (report_opcode_val),
		.res_free      (res_free),
		.res_load      (res_load),
		.res_data      (res_data)
	);

	sfd_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res_data  (res_data),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_out   (res_out)
	);

	assign checksum_ok    = res_out.checksum_ok;
	assign frame_opcode   = res_out.frame_opcode;
	assign data_length    = res_out.data_length;
	assign zone_left      = res_out.zone_left;
	assign zone_middle    = res_out.zone_middle;
	assign zone_right     = res_out.zone_right;
	assign is_zone_report = res_out.is_zone_report;

endmodule
`default_nettype wire

### rtl/sfd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer configuration registers
// APB-style register port holding the zone report opcode.
// ----------------------------------------------------------------------------
module sfd_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output logic      [7:0]                 report_opcode
);
	import sfd_pkg::*;

	logic [7:0] report_opcode_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Registers are word aligned; the low two address bits are not decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_opcode_q <= REPORT_OPCODE_RST;
		end else if (wr_en && (paddr[2] == REG_REPORT_OPCODE)) begin
			report_opcode_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'h0;
		if (paddr[2] == REG_REPORT_OPCODE) begin
			prdata = {24'h0, report_opcode_q};
		end
	end

	assign report_opcode = report_opcode_q;

endmodule
`default_nettype wire

### rtl/sfd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer core
// Input byte register, header hunting, frame collection and checksum check.
// ----------------------------------------------------------------------------
module sfd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	output logic                    rx_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [7:0]         report_opcode,
	input  wire logic               res_free,
	output logic                    res_load,
	output sfd_pkg::sfd_result_t    res_data
);
	import sfd_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Deframer state
	sfd_state_t state_q, state_d;
	logic [1:0] fill_q, fill_d;
	logic [7:0] win_q [3];
	logic [7:0] win_d [3];
	logic [7:0] data_left_q, data_left_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0] opcode_q, opcode_d;
	logic [7:0] length_q, length_d;
	logic [7:0] zones_q [3];
	logic [7:0] zones_d [3];
	logic [1:0] zidx_q, zidx_d;
	logic [7:0] trail_hi_q, trail_hi_d;

	logic advance;
	logic hdr_ok;
	logic csum_ok;

	// A frame-ending byte waits until the result register can take its result.
	assign advance  = valid_s1 && ((state_q != ST_TRAIL_LO) || res_free);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign hdr_ok = (fill_q == 2'd3) && (win_q[0] == SYNC_FIRST) &&
		(win_q[1] == SYNC_SECOND) && ({1'b0, byte_s1} >= LEN_MIN) &&
		({1'b0, byte_s1} <= LEN_MAX);

	assign csum_ok = ({trail_hi_q, byte_s1} == sum_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HUNT: begin
				if (hdr_ok) begin
					state_d = ({1'b0, byte_s1} == LEN_MIN) ? ST_TRAIL_HI : ST_DATA;
				end
			end
			ST_DATA: begin
				if (data_left_q == 8'd1) begin
					state_d = ST_TRAIL_HI;
				end
			end
			ST_TRAIL_HI: state_d = ST_TRAIL_LO;
			ST_TRAIL_LO: state_d = ST_HUNT;
			default:     state_d = ST_HUNT;
		endcase
	end

	// Datapath and result
	always_comb begin
		fill_d      = fill_q;
		win_d       = win_q;
		data_left_d = data_left_q;
		sum_d       = sum_q;
		opcode_d    = opcode_q;
		length_d    = length_q;
		zones_d     = zones_q;
		zidx_d      = zidx_q;
		trail_hi_d  = trail_hi_q;
		res_load    = 1'b0;

		res_data.checksum_ok    = csum_ok;
		res_data.frame_opcode   = opcode_q;
		res_data.data_length    = length_q;
		res_data.zone_left      = zones_q[0];
		res_data.zone_middle    = zones_q[1];
		res_data.zone_right     = zones_q[2];
		res_data.is_zone_report = csum_ok && (opcode_q == report_opcode);

		case (state_q)
			ST_HUNT: begin
				if (fill_q != 2'd3) begin
					for (int i = 0; i < 3; i++) begin
						if (fill_q == 2'(i)) begin
							win_d[i] = byte_s1;
						end
					end
					fill_d = fill_q + 2'd1;
				end else if (hdr_ok) begin
					opcode_d    = win_q[2];
					length_d    = byte_s1 - 8'd2;
					data_left_d = byte_s1 - 8'd2;
					sum_d       = {8'h0, SYNC_FIRST} + {8'h0, SYNC_SECOND} +
						{8'h0, win_q[2]} + {8'h0, byte_s1};
					zones_d     = '{default: 8'h0};
					zidx_d      = 2'd0;
				end else begin
					win_d[0] = win_q[1];
					win_d[1] = win_q[2];
					win_d[2] = byte_s1;
				end
			end
			ST_DATA: begin
				for (int i = 0; i < 3; i++) begin
					if (zidx_q == 2'(i)) begin
						zones_d[i] = byte_s1;
					end
				end
				if (zidx_q != 2'd3) begin
					zidx_d = zidx_q + 2'd1;
				end
				sum_d       = sum_q + {8'h0, byte_s1};
				data_left_d = data_left_q - 8'd1;
			end
			ST_TRAIL_HI: begin
				trail_hi_d = byte_s1;
			end
			ST_TRAIL_LO: begin
				res_load = advance;
				fill_d   = 2'd0;
			end
			default: begin
				fill_d = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			fill_q  <= 2'd0;
		end else if (advance) begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q       <= win_d;
			data_left_q <= data_left_d;
			sum_q       <= sum_d;
			opcode_q    <= opcode_d;
			length_q    <= length_d;
			zones_q     <= zones_d;
			zidx_q      <= zidx_d;
			trail_hi_q  <= trail_hi_d;
		end
	end

endmodule
`default_nettype wire

### rtl/sfd_outreg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one frame result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module sfd_outreg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 res_load,
	input  wire sfd_pkg::sfd_result_t res_data,
	output logic                      res_free,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output sfd_pkg::sfd_result_t      res_out
);
	import sfd_pkg::*;

	logic        valid_q;
	sfd_result_t data_q;

	assign res_free  = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_out   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			data_q <= res_data;
		end
	end

endmodule
`default_nettype wire

### rtl/sfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks result consistency and the result handshake at the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic       checksum_ok,
	input wire logic [7:0] frame_opcode,
	input wire logic [7:0] data_length,
	input wire logic [7:0] zone_left,
	input wire logic [7:0] zone_middle,
	input wire logic [7:0] zone_right,
	input wire logic       is_zone_report
);
	import sfd_pkg::*;

	// A stalled result transfer keeps its valid and its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(checksum_ok) &&
		$stable(frame_opcode) && $stable(data_length) && $stable(zone_left) &&
		$stable(zone_middle) && $stable(zone_right) && $stable(is_zone_report))
		else $error("result changed while stalled");

	// A zone report is only flagged for a frame whose checksum matched.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_zone_report |-> checksum_ok)
		else $error("zone report without a good checksum");

	// The header check bounds the data length by the frame limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> data_length <= DATA_MAX)
		else $error("data length above the frame limit");

	// Zone bytes beyond the data of a short frame read as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (data_length != 8'd0 || zone_left == 8'h0) &&
		(data_length > 8'd1 || zone_middle == 8'h0) &&
		(data_length > 8'd2 || zone_right == 8'h0))
		else $error("zone byte set beyond the frame data");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.checksum_ok    (checksum_ok),
	.frame_opcode   (frame_opcode),
	.data_length    (data_length),
	.zone_left      (zone_left),
	.zone_middle    (zone_middle),
	.zone_right     (zone_right),
	.is_zone_report (is_zone_report)
);
`default_nettype wire

### tb/sv/frame_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame report checker
// Watches the byte input, the result output and the register port of the
// serial frame deframer. Every accepted byte goes through a cycle-free model
// of the frame hunter; each finished frame queues the report that the block
// must produce, and every report transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module frame_report_checker
	import sfd_pkg::*;
#(
	parameter logic [PADDR_W-1:0] REPORT_ADDR = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	input  logic               rx_stall,
	input  logic [7:0]         rx_byte,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic               checksum_ok,
	input  logic [7:0]         frame_opcode,
	input  logic [7:0]         data_length,
	input  logic [7:0]         zone_left,
	input  logic [7:0]         zone_middle,
	input  logic [7:0]         zone_right,
	input  logic               is_zone_report,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 reports_pending
);

	localparam int SHOWN_MISMATCHES = 10;

	sfd_result_t frame_reports[$];

	// Model of the hunter and the frame being collected.
	logic [7:0]  report_op;
	logic [7:0]  hunt_win[3];
	int          hunt_fill;
	logic        framing;
	logic [8:0]  remaining;
	logic [15:0] frame_sum;
	logic [7:0]  cur_opcode;
	logic [7:0]  cur_len;
	logic [7:0]  zone_bytes[3];
	logic [7:0]  trail_msb;

	function automatic string describe_report(sfd_result_t r);
		return $sformatf("ok=%0d op=%02h len=%0d zones=%02h/%02h/%02h report=%0d",
			r.checksum_ok, r.frame_opcode, r.data_length, r.zone_left,
			r.zone_middle, r.zone_right, r.is_zone_report);
	endfunction

	function automatic void log_mismatch(string msg);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("%0t ns: %s", $time, msg);
	endfunction

	function automatic void restart_hunt();
		for (int i = 0; i < 3; i++) begin
			hunt_win[i] = 8'h00;
			zone_bytes[i] = 8'h00;
		end
		hunt_fill = 0;
		framing = 1'b0;
		remaining = '0;
		frame_sum = '0;
		cur_opcode = '0;
		cur_len = '0;
		trail_msb = '0;
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		sfd_result_t r;
		logic [15:0] trailer;
		logic [8:0]  pos;
		if (!framing) begin
			if (hunt_fill < 3) begin
				hunt_win[hunt_fill] = b;
				hunt_fill++;
			end else if (hunt_win[0] == SYNC_FIRST && hunt_win[1] == SYNC_SECOND &&
					{1'b0, b} >= LEN_MIN && {1'b0, b} <= LEN_MAX) begin
				framing = 1'b1;
				cur_opcode = hunt_win[2];
				cur_len = b - 8'd2;
				remaining = {1'b0, b};
				frame_sum = 16'(SYNC_FIRST) + 16'(SYNC_SECOND) + 16'(hunt_win[2]) + 16'(b);
				for (int i = 0; i < 3; i++)
					zone_bytes[i] = 8'h00;
				trail_msb = 8'h00;
			end else begin
				// A rejected window drops its oldest byte.
				hunt_win[0] = hunt_win[1];
				hunt_win[1] = hunt_win[2];
				hunt_win[2] = b;
			end
		end else if (remaining > 9'd2) begin
			pos = 9'(cur_len) + 9'd2 - remaining;
			if (pos < 9'd3)
				zone_bytes[pos] = b;
			frame_sum = frame_sum + 16'(b);
			remaining = remaining - 9'd1;
		end else if (remaining == 9'd2) begin
			trail_msb = b;
			remaining = 9'd1;
		end else begin
			trailer = {trail_msb, b};
			r.checksum_ok = (trailer == frame_sum);
			r.frame_opcode = cur_opcode;
			r.data_length = cur_len;
			r.zone_left = zone_bytes[0];
			r.zone_middle = zone_bytes[1];
			r.zone_right = zone_bytes[2];
			r.is_zone_report = r.checksum_ok && (cur_opcode == report_op);
			frame_reports.push_back(r);
			restart_hunt();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sfd_result_t got;
		sfd_result_t want;
		if (!arst_n) begin
			restart_hunt();
			report_op = REPORT_OPCODE_RST;
			frame_reports.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pready && paddr == REPORT_ADDR) begin
				if (pwrite)
					report_op = pwdata[7:0];
				else if (prdata[7:0] !== report_op)
					log_mismatch($sformatf("report opcode read: expected %02h, got %02h",
						report_op, prdata[7:0]));
			end
			// Compare before predicting so a report never meets its own frame's byte.
			if (res_valid && !res_stall) begin
				got.checksum_ok = checksum_ok;
				got.frame_opcode = frame_opcode;
				got.data_length = data_length;
				got.zone_left = zone_left;
				got.zone_middle = zone_middle;
				got.zone_right = zone_right;
				got.is_zone_report = is_zone_report;
				if (frame_reports.size() == 0) begin
					log_mismatch({"report with none expected: ", describe_report(got)});
				end else begin
					want = frame_reports.pop_front();
					if (got.checksum_ok !== want.checksum_ok ||
							got.frame_opcode !== want.frame_opcode ||
							got.data_length !== want.data_length ||
							got.zone_left !== want.zone_left ||
							got.zone_middle !== want.zone_middle ||
							got.zone_right !== want.zone_right ||
							got.is_zone_report !== want.is_zone_report)
						log_mismatch({"expected ", describe_report(want), "; got ",
							describe_report(got)});
				end
			end
			if (rx_valid && !rx_stall)
				deframe_byte(rx_byte);
		end
		reports_pending = frame_reports.size();
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame deframer testbench
// Feeds byte streams of framed packets, noise and broken headers to the
// deframer under random sender bursts and receiver stalls, steps the report
// opcode register through several values and lets the checker judge every
// report transfer.
// ----------------------------------------------------------------------------
module testbench;
	import sfd_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_REPORT_OPCODE = PADDR_W'(4 * int'(REG_REPORT_OPCODE));
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED =
		PADDR_W'(4 * (int'(REG_REPORT_OPCODE) + 1));
	localparam int  PHASE_BYTES  = 450;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  QUIET_LIMIT  = 20000;
	localparam time RUN_LIMIT    = 2_000_000;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

	logic                clk;
	logic                arst_n;
	logic                rx_valid;
	logic                rx_stall;
	logic [7:0]          rx_byte;
	logic                res_valid;
	logic                res_stall;
	logic                checksum_ok;
	logic [7:0]          frame_opcode;
	logic [7:0]          data_length;
	logic [7:0]          zone_left;
	logic [7:0]          zone_middle;
	logic [7:0]          zone_right;
	logic                is_zone_report;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	int                  mismatches;
	int                  reports_pending;

	logic [7:0] rx_stream[$];
	logic [7:0] cur_report;

	serial_frame_deframer dut (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.checksum_ok(checksum_ok), .frame_opcode(frame_opcode),
		.data_length(data_length), .zone_left(zone_left),
		.zone_middle(zone_middle), .zone_right(zone_right),
		.is_zone_report(is_zone_report),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	frame_report_checker #(.REPORT_ADDR(ADDR_REPORT_OPCODE)) report_check (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.checksum_ok(checksum_ok), .frame_opcode(frame_opcode),
		.data_length(data_length), .zone_left(zone_left),
		.zone_middle(zone_middle), .zone_right(zone_right),
		.is_zone_report(is_zone_report),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mismatches(mismatches), .reports_pending(reports_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// The report side stalls in stretches of changing character.
	initial begin : report_stall_pattern
		stall_mode_t mode;
		int span;
		res_stall <= 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = (mode == STALL_HOLD) ? $urandom_range(1, 30) : $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:  res_stall <= 1'b0;
					STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
					default:     res_stall <= 1'b1;
				endcase
			end
		end
	end

	task automatic apb_access(input bit write, input logic [PADDR_W-1:0] addr,
			input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic queue_frame(input logic [7:0] opcode, input logic [7:0] payload[$],
			input bit corrupt);
		logic [15:0] sum;
		logic [15:0] trailer;
		logic [7:0]  len;
		len = 8'(payload.size() + 2);
		sum = 16'(SYNC_FIRST) + 16'(SYNC_SECOND) + 16'(opcode) + 16'(len);
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(SYNC_SECOND);
		rx_stream.push_back(opcode);
		rx_stream.push_back(len);
		foreach (payload[i]) begin
			sum = sum + 16'(payload[i]);
			rx_stream.push_back(payload[i]);
		end
		trailer = corrupt ? (sum ^ 16'($urandom_range(1, 65535))) : sum;
		rx_stream.push_back(trailer[15:8]);
		rx_stream.push_back(trailer[7:0]);
	endtask

	task automatic queue_random_frame(input int n_data, input bit corrupt);
		logic [7:0] payload[$];
		logic [7:0] opcode;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: opcode = cur_report;
			4:          opcode = 8'h00;
			5:          opcode = 8'hFF;
			default:    opcode = 8'($urandom);
		endcase
		repeat (n_data) payload.push_back(8'($urandom));
		queue_frame(opcode, payload, corrupt);
	endtask

	// Noise never forms a sync pair and broken headers carry a length out of
	// range, so every phase ends back in hunting and only real headers open a frame.
	task automatic queue_traffic(input int n_bytes);
		logic [7:0] b;
		int pick;
		int n_data;
		while (rx_stream.size() < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					n_data = $urandom_range(0, 6);
				else if (pick < 96)
					n_data = $urandom_range(7, 30);
				else
					n_data = $urandom_range(31, int'(DATA_MAX));
				queue_random_frame(n_data, $urandom_range(0, 4) == 0);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0:       b = SYNC_FIRST;
						1:       b = SYNC_SECOND;
						default: b = 8'($urandom);
					endcase
					while (b == SYNC_SECOND && rx_stream.size() > 0 &&
							rx_stream[$] == SYNC_FIRST)
						b = 8'($urandom);
					rx_stream.push_back(b);
				end
			end else if (pick < 95) begin
				rx_stream.push_back(SYNC_FIRST);
				rx_stream.push_back(SYNC_SECOND);
				rx_stream.push_back(8'($urandom));
				rx_stream.push_back(($urandom_range(0, 1) == 0) ?
					8'($urandom_range(0, int'(LEN_MIN) - 1)) :
					8'($urandom_range(int'(LEN_MAX) + 1, 255)));
			end else begin
				b = 8'($urandom);
				while (b == SYNC_SECOND) b = 8'($urandom);
				rx_stream.push_back(SYNC_FIRST);
				rx_stream.push_back(b);
			end
		end
		queue_random_frame($urandom_range(0, 6), 1'b0);
	endtask

	// Bytes leave in bursts; gaps of zero let bursts run together.
	task automatic send_stream();
		int burst;
		int gap;
		while (rx_stream.size() != 0) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 24);
			while (burst > 0 && rx_stream.size() != 0) begin
				rx_valid <= 1'b1;
				rx_byte <= rx_stream.pop_front();
				@(posedge clk);
				while (rx_stall) @(posedge clk);
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				rx_byte <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		rx_valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		int waited;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while (reports_pending != 0 && waited < QUIET_LIMIT);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [PADDR_W-1:0] addr, input logic [7:0] value,
			input bit with_longest);
		apb_access(1'b1, addr, value);
		if (addr == ADDR_REPORT_OPCODE)
			cur_report = value;
		apb_access(1'b0, ADDR_REPORT_OPCODE, 8'h00);
		if (with_longest)
			queue_random_frame(int'(DATA_MAX), 1'b0);
		queue_traffic(PHASE_BYTES);
		send_stream();
		wait_quiet();
	endtask

	initial begin : stimulus
		logic [7:0] payload[$];
		rx_valid <= 1'b0;
		rx_byte <= 8'h00;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		cur_report = REPORT_OPCODE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, ADDR_REPORT_OPCODE, 8'h00);

		// Shortest frame, carrying the report opcode that reset leaves.
		payload.delete();
		queue_frame(REPORT_OPCODE_RST, payload, 1'b0);
		// Headers whose totals fall just below and just above the legal range.
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(SYNC_SECOND);
		rx_stream.push_back(8'h01);
		rx_stream.push_back(8'(LEN_MIN - 9'd1));
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(SYNC_SECOND);
		rx_stream.push_back(8'h00);
		rx_stream.push_back(8'(LEN_MAX + 9'd1));
		// Bad checksum still reports its data byte.
		payload = {8'hFF};
		queue_frame(8'hFF, payload, 1'b1);
		// More data bytes than zone fields.
		payload = {8'h00, 8'hFF, 8'h80, 8'h7F};
		queue_frame(8'h00, payload, 1'b0);
		send_stream();
		wait_quiet();

		run_phase(ADDR_REPORT_OPCODE, 8'h00, 1'b1);
		run_phase(ADDR_UNMAPPED, 8'hA5, 1'b0);
		run_phase(ADDR_REPORT_OPCODE, 8'hFF, 1'b0);
		run_phase(ADDR_REPORT_OPCODE, 8'($urandom), 1'b0);

		if (mismatches == 0 && reports_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### serial_frame_deframer.f
rtl/sfd_pkg.sv
rtl/sfd_cfg.sv
rtl/sfd_core.sv
rtl/sfd_outreg.sv
rtl/serial_frame_deframer.sv
rtl/sfd_checker.sv
tb/sv/frame_report_checker.sv
tb/sv/testbench.sv
